[rtl/core/hbd_pkg.sv]
// Shared types, constants and helpers of the HTTP body dechunker.
`default_nettype none

package hbd_pkg;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   localparam int BODY_LEN_W = 32;

   typedef enum logic [1:0] {
      PH_SIZE,
      PH_DATA,
      PH_TRAIL,
      PH_DONE
   } hbd_phase_type;

   typedef enum logic {
      REG_BODY_MODE   = 1'b0,
      REG_BODY_LENGTH = 1'b1
   } hbd_reg_type;

   // Per-beat outcome of the chunked parser, already including this beat.
   typedef struct packed {
      logic payload_valid;
      logic chunk_last;
      logic body_done;
      logic header_error;
   } hbd_chunk_res_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hbd_hex_type;

   function automatic hbd_hex_type hex_decode(input logic [7:0] c);
      hbd_hex_type h;
      h.is_hex = 1'b1;
      h.value  = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else begin
         h.is_hex = 1'b0;
      end
      return h;
   endfunction

endpackage

`default_nettype wire

[rtl/core/hbd_req_if.sv]
// Input channel: one raw byte per beat.
`default_nettype none

interface hbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/hbd_rsp_if.sv]
// Result channel: one decoded result per input beat.
`default_nettype none

interface hbd_rsp_if;
   logic       valid;
   logic       ready;
   logic       payload_valid;
   logic [7:0] payload_byte;
   logic       chunk_last;
   logic       body_done;
   logic       header_error;

   modport source (output valid, output payload_valid, output payload_byte,
                   output chunk_last, output body_done, output header_error,
                   input ready);
   modport sink (input valid, input payload_valid, input payload_byte,
                 input chunk_last, input body_done, input header_error,
                 output ready);
endinterface

`default_nettype wire

[rtl/core/hbd_chunk_parser.sv]
// Chunked transfer encoding parser: size line, chunk data and trailing line.
`default_nettype none

module hbd_chunk_parser #(
   parameter int LINE_BUFFER_LEN = 32,
   parameter int SIZE_WIDTH      = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       step,
   input  wire logic [7:0]                 in_byte,
   output      logic                       error_held,
   output      hbd_pkg::hbd_chunk_res_type res
);
   import hbd_pkg::*;

   localparam int LC_W = $clog2(LINE_BUFFER_LEN);

   hbd_phase_type         phase_ff, phase_in;
   logic                  pending_cr_ff, pending_cr_in;
   logic                  hex_stopped_ff, hex_stopped_in;
   logic [LC_W-1:0]       line_count_ff, line_count_in;
   logic [SIZE_WIDTH-1:0] chunk_total_ff, chunk_total_in;
   logic [SIZE_WIDTH-1:0] chunk_seen_ff, chunk_seen_in;
   logic [SIZE_WIDTH-1:0] seen_plus;
   logic                  error_ff, error_in;
   hbd_hex_type           hex;

   assign hex       = hex_decode(in_byte);
   assign seen_plus = chunk_seen_ff + SIZE_WIDTH'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_SIZE;
         pending_cr_ff  <= 1'b0;
         hex_stopped_ff <= 1'b0;
         line_count_ff  <= '0;
         chunk_total_ff <= '0;
         chunk_seen_ff  <= '0;
         error_ff       <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         pending_cr_ff  <= pending_cr_in;
         hex_stopped_ff <= hex_stopped_in;
         line_count_ff  <= line_count_in;
         chunk_total_ff <= chunk_total_in;
         chunk_seen_ff  <= chunk_seen_in;
         error_ff       <= error_in;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      pending_cr_in  = pending_cr_ff;
      hex_stopped_in = hex_stopped_ff;
      line_count_in  = line_count_ff;
      chunk_total_in = chunk_total_ff;
      chunk_seen_in  = chunk_seen_ff;
      error_in       = error_ff;
      res            = '0;
      if (step) begin
         unique case (phase_ff)
            PH_SIZE: begin
               // An LF ends the line whether or not a CR came first, and a CR
               // after a dropped CR simply becomes the new pending CR.
               if (in_byte == CH_LF) begin
                  pending_cr_in  = 1'b0;
                  hex_stopped_in = 1'b0;
                  line_count_in  = '0;
                  chunk_seen_in  = '0;
                  phase_in       = (chunk_total_ff == '0) ? PH_DONE : PH_DATA;
               end else if (in_byte == CH_CR) begin
                  pending_cr_in = 1'b1;
               end else begin
                  pending_cr_in = 1'b0;
                  if (!hex_stopped_ff && hex.is_hex) begin
                     if (|chunk_total_ff[SIZE_WIDTH-1:SIZE_WIDTH-4]) begin
                        chunk_total_in = '1;
                     end else begin
                        chunk_total_in = {chunk_total_ff[SIZE_WIDTH-5:0], hex.value};
                     end
                  end else begin
                     hex_stopped_in = 1'b1;
                  end
                  line_count_in = line_count_ff + LC_W'(1);
                  if (line_count_ff == LC_W'(LINE_BUFFER_LEN - 2)) begin
                     error_in = 1'b1;
                  end
               end
            end
            PH_DATA: begin
               res.payload_valid = 1'b1;
               if (seen_plus == chunk_total_ff) begin
                  res.chunk_last = 1'b1;
                  chunk_total_in = '0;
                  chunk_seen_in  = '0;
                  phase_in       = PH_TRAIL;
               end else begin
                  chunk_seen_in = seen_plus;
               end
            end
            PH_TRAIL: begin
               if (in_byte == CH_LF) begin
                  phase_in = PH_SIZE;
               end
            end
            PH_DONE: begin
               phase_in = PH_DONE;
            end
            default: begin
               phase_in = PH_DONE;
            end
         endcase
         res.body_done = !error_in && (phase_in == PH_DONE);
      end
      res.header_error = error_in;
   end

   assign error_held = error_ff;

endmodule

`default_nettype wire

[rtl/core/http_body_dechunker.sv]
// HTTP body dechunker top level: channels, register port and result register.
//
// The req_ch channel carries one raw connection byte per beat. Every accepted
// beat yields exactly one beat on rsp_ch: payload_valid and payload_byte say
// whether the byte is body payload, chunk_last marks the final byte of a
// chunk, body_done is high once the body is complete and header_error is a
// sticky flag for a chunk size line that grew too long without a line end.
// body_mode (address 0) selects length-delimited (0) or chunked (1) bodies;
// body_length (address 4) gives the byte count in length mode. Registers must
// be written over the APB-style csr_ port only while the block is idle; the
// block does not enforce this. A result beat appears in the cycle after its
// input beat is accepted; one beat is accepted per cycle unless the receiver
// stalls. The parser state updates in the same cycle by one step of short
// logic, and the result lands in a single output register, which holds its
// beat on a stall while req_ch.ready stays low until it is taken. Synchronous
// reset returns the parser to the start of a size line, clears all counters
// and the error flag, zeroes both registers and empties the output register.
`default_nettype none

module http_body_dechunker #(
   parameter int LINE_BUFFER_LEN = 32,
   parameter int SIZE_WIDTH      = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   hbd_req_if.sink          req_ch,
   hbd_rsp_if.source        rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);
   import hbd_pkg::*;

   logic                  body_mode_ff;
   logic [BODY_LEN_W-1:0] body_length_ff;
   logic [BODY_LEN_W-1:0] body_seen_ff, body_seen_in;
   logic [BODY_LEN_W-1:0] body_seen_plus;
   logic                  body_open;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  payload_valid_ff, payload_valid_in;
   logic [7:0]            payload_byte_ff, payload_byte_in;
   logic                  chunk_last_ff, chunk_last_in;
   logic                  body_done_ff, body_done_in;
   logic                  header_error_ff, header_error_in;

   logic                  accept;
   logic                  chunk_step;
   logic                  error_held;
   hbd_chunk_res_type     chunk_res;
   hbd_reg_type           reg_sel;
   logic                  csr_write;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = hbd_reg_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         body_mode_ff   <= 1'b0;
         body_length_ff <= '0;
      end else if (csr_write) begin
         unique case (reg_sel)
            REG_BODY_MODE:   body_mode_ff   <= csr_pwdata[0];
            REG_BODY_LENGTH: body_length_ff <= csr_pwdata;
            default:         body_mode_ff   <= body_mode_ff;
         endcase
      end
   end

   // Misaligned addresses read as zero.
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         unique case (reg_sel)
            REG_BODY_MODE:   csr_prdata = {31'd0, body_mode_ff};
            REG_BODY_LENGTH: csr_prdata = body_length_ff;
            default:         csr_prdata = '0;
         endcase
      end
   end

   // ---------------- input side ----------------
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign chunk_step   = accept && body_mode_ff && !error_held;

   hbd_chunk_parser #(
      .LINE_BUFFER_LEN (LINE_BUFFER_LEN),
      .SIZE_WIDTH      (SIZE_WIDTH)
   ) u_chunk (
      .clock      (clock),
      .reset      (reset),
      .step       (chunk_step),
      .in_byte    (req_ch.in_byte),
      .error_held (error_held),
      .res        (chunk_res)
   );

   // ---------------- length mode and result selection ----------------
   assign body_open      = body_seen_ff < body_length_ff;
   assign body_seen_plus = body_seen_ff + BODY_LEN_W'(1);

   always_comb begin
      body_seen_in     = body_seen_ff;
      payload_valid_in = 1'b0;
      chunk_last_in    = 1'b0;
      body_done_in     = 1'b0;
      header_error_in  = 1'b0;
      if (error_held) begin
         header_error_in = 1'b1;
      end else if (!body_mode_ff) begin
         payload_valid_in = body_open;
         body_done_in     = body_open ? (body_seen_plus == body_length_ff) : 1'b1;
         if (accept && body_open) begin
            body_seen_in = body_seen_plus;
         end
      end else begin
         payload_valid_in = chunk_res.payload_valid;
         chunk_last_in    = chunk_res.chunk_last;
         body_done_in     = chunk_res.body_done;
         header_error_in  = chunk_res.header_error;
      end
      payload_byte_in = payload_valid_in ? req_ch.in_byte : 8'd0;
      rsp_valid_in    = accept || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         body_seen_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         body_seen_ff <= body_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         payload_valid_ff <= payload_valid_in;
         payload_byte_ff  <= payload_byte_in;
         chunk_last_ff    <= chunk_last_in;
         body_done_ff     <= body_done_in;
         header_error_ff  <= header_error_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.payload_valid = payload_valid_ff;
   assign rsp_ch.payload_byte  = payload_byte_ff;
   assign rsp_ch.chunk_last    = chunk_last_ff;
   assign rsp_ch.body_done     = body_done_ff;
   assign rsp_ch.header_error  = header_error_ff;

   // ---------------- assertions ----------------
   a_last_is_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && chunk_last_ff |-> payload_valid_ff)
      else $error("chunk_last on a beat without payload");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      error_held |=> error_held)
      else $error("header error flag cleared without reset");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready |-> !req_ch.ready)
      else $error("input accepted while the result register is stalled");

   a_error_drops_beat: assert property (@(posedge clock) disable iff (reset)
      accept && error_held |=> !payload_valid_ff && !body_done_ff && header_error_ff)
      else $error("beat not dropped after a header error");

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the HTTP body dechunker: directed table, random chunk streams.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import hbd_pkg::*;

   localparam int RESET_CYCLES = 11;
   localparam int RANDOM_ITEMS = 750;
   localparam int QUIET_LIMIT  = 500;
   localparam int LINE_LEN     = 32;
   localparam logic [31:0] SIZE_ONES = 32'hFFFF_FFFF;
   localparam int DIR_ROWS     = 23;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       chunk_last;
      logic       body_done;
      logic       header_error;
   } body_beat_type;

   typedef enum logic {
      DO_BYTE,
      DO_WRITE
   } step_kind_type;

   typedef enum int {
      CLOSE_ZERO,
      CLOSE_LONG,
      CLOSE_HUGE
   } close_kind_type;

   typedef struct {
      step_kind_type kind;
      hbd_reg_type   sel;
      logic [31:0]   value;
      bit            typed;
      body_beat_type beat;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   hbd_req_if req_ch ();
   hbd_rsp_if rsp_ch ();

   http_body_dechunker i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #1 clock = ~clock;

   // Decoder state as predicted, plus its copy of the registers.
   hbd_phase_type dec_phase       = PH_SIZE;
   bit            dec_pending_cr  = 1'b0;
   bit            dec_hex_stopped = 1'b0;
   int            dec_line_len    = 0;
   logic [31:0]   dec_chunk_size  = '0;
   logic [31:0]   dec_chunk_count = '0;
   logic [31:0]   dec_body_count  = '0;
   bit            dec_error       = 1'b0;
   bit            cfg_chunked     = 1'b0;
   logic [31:0]   cfg_body_length = '0;

   body_beat_type sent_beats[$];
   body_beat_type expected_beats[$];
   dir_row_type   steps[DIR_ROWS];

   bit             idle_on = 1'b1;
   int             errors = 0;
   int             bytes_sent = 0;
   int             payload_seen = 0;
   int             chunk_ends = 0;
   int             reg_writes = 0;
   close_kind_type closing;

   // Bit 4 flags a hex digit, bits 3:0 carry its value.
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [7:0] folded;
      folded = c | 8'h20;
      if (c >= 8'h30 && c <= 8'h39) begin
         return {1'b1, 4'(c - 8'h30)};
      end else if (folded >= 8'h61 && folded <= 8'h66) begin
         return {1'b1, 4'(folded - 8'h57)};
      end
      return 5'b0;
   endfunction

   function automatic body_beat_type decode_byte(input logic [7:0] c);
      body_beat_type beat;
      logic [4:0]    nib;
      bit            line_done;
      beat = '0;
      line_done = 1'b0;
      nib = hex_nibble(c);
      if (dec_error) begin
         // An overrun size line freezes the decoder until reset.
      end else if (!cfg_chunked) begin
         if (dec_body_count < cfg_body_length) begin
            beat.payload_valid = 1'b1;
            dec_body_count++;
         end
         beat.body_done = (dec_body_count >= cfg_body_length);
      end else begin
         case (dec_phase)
            PH_SIZE: begin
               // A CR only counts as a line end when LF follows right away.
               if (dec_pending_cr) begin
                  dec_pending_cr = 1'b0;
                  line_done = (c == CH_LF);
               end
               if (!line_done) begin
                  if (c == CH_CR) begin
                     dec_pending_cr = 1'b1;
                  end else if (c == CH_LF) begin
                     line_done = 1'b1;
                  end else begin
                     if (!dec_hex_stopped && nib[4]) begin
                        if (dec_chunk_size > (SIZE_ONES >> 4)) begin
                           dec_chunk_size = SIZE_ONES;
                        end else begin
                           dec_chunk_size = {dec_chunk_size[27:0], nib[3:0]};
                        end
                     end else begin
                        dec_hex_stopped = 1'b1;
                     end
                     dec_line_len++;
                     if (dec_line_len >= LINE_LEN - 1) begin
                        dec_error = 1'b1;
                     end
                  end
               end
               if (line_done) begin
                  dec_pending_cr  = 1'b0;
                  dec_hex_stopped = 1'b0;
                  dec_line_len    = 0;
                  dec_chunk_count = '0;
                  dec_phase = (dec_chunk_size == 0) ? PH_DONE : PH_DATA;
               end
            end
            PH_DATA: begin
               beat.payload_valid = 1'b1;
               dec_chunk_count++;
               if (dec_chunk_count >= dec_chunk_size) begin
                  beat.chunk_last = 1'b1;
                  dec_chunk_size  = '0;
                  dec_chunk_count = '0;
                  dec_phase = PH_TRAIL;
               end
            end
            PH_TRAIL: begin
               if (c == CH_LF) begin
                  dec_phase = PH_SIZE;
               end
            end
            default: begin
               dec_phase = PH_DONE;
            end
         endcase
         beat.body_done = !dec_error && dec_phase == PH_DONE;
      end
      beat.payload_byte = beat.payload_valid ? c : 8'h00;
      beat.header_error = dec_error;
      return beat;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input body_beat_type typed_beat = '0);
      body_beat_type beat;
      int            gap;
      bit            took;
      beat = decode_byte(b);
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      sent_beats.push_back(typed ? typed_beat : beat);
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      do begin
         @(posedge clock);
         took = req_ch.ready;
         @(negedge clock);
      end while (!took);
      bytes_sent++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (sent_beats.size() != 0 || expected_beats.size() != 0) begin
         @(negedge clock);
      end
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(input hbd_reg_type sel, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (sel == REG_BODY_MODE) begin
         cfg_chunked = value[0];
      end else begin
         cfg_body_length = value;
      end
      reg_writes++;
      @(negedge clock);
   endtask

   function automatic logic [7:0] byte_except(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] ch;
      do ch = 8'($urandom_range(0, 255)); while (ch == a || ch == b);
      return ch;
   endfunction

   // Switches to length mode in the middle of a chunked body and back again.
   task automatic length_interlude();
      logic [31:0] len;
      wait_idle();
      write_reg(REG_BODY_MODE, 32'd0);
      case ($urandom_range(0, 3))
         0: len = dec_body_count + $urandom_range(1, 12);
         1: len = $urandom();
         2: len = 32'd0;
         default: len = SIZE_ONES;
      endcase
      write_reg(REG_BODY_LENGTH, len);
      repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
      wait_idle();
      write_reg(REG_BODY_MODE, 32'd1);
   endtask

   task automatic send_chunk();
      int         size;
      int         nibbles;
      int         split;
      int         count;
      bit         upper;
      logic [3:0] nib;
      logic [7:0] ch;
      logic [4:0] hx;
      size = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 16);
      nibbles = (size > 15) ? 2 : 1;
      upper = 1'($urandom_range(0, 1));
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      repeat (count) send_byte(8'h30);
      for (int i = nibbles - 1; i >= 0; i--) begin
         nib = 4'(size >> (4 * i));
         ch = (nib < 4'd10) ? 8'h30 + 8'(nib)
                            : (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
         send_byte(ch);
      end
      // Line extension: starts with a non-hex byte so the size is final.
      if ($urandom_range(0, 2) == 0) begin
         do begin
            ch = byte_except(CH_CR, CH_LF);
            hx = hex_nibble(ch);
         end while (hx[4]);
         send_byte(ch);
         count = $urandom_range(0, 7);
         repeat (count) send_byte(byte_except(CH_LF, CH_LF));
      end
      if ($urandom_range(0, 1) == 1) begin
         send_byte(CH_CR);
      end
      send_byte(CH_LF);
      split = ($urandom_range(0, 5) == 0) ? $urandom_range(0, size - 1) : size;
      for (int k = 0; k < size; k++) begin
         if (k == split) begin
            length_interlude();
         end
         send_byte(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 4)) send_byte(byte_except(CH_LF, CH_LF));
      end
      if ($urandom_range(0, 1) == 1) begin
         send_byte(CH_CR);
      end
      send_byte(CH_LF);
   endtask

   task automatic close_body();
      closing = close_kind_type'($urandom_range(0, 2));
      case (closing)
         CLOSE_ZERO: begin
            send_byte(8'h30);
            if ($urandom_range(0, 1) == 1) begin
               send_byte(8'h3B);
               send_byte(8'h7A);
            end
            send_byte(CH_CR);
            send_byte(CH_LF);
            // Bytes after the body are dropped with done held high.
            repeat (4) send_byte(8'($urandom_range(0, 255)));
            wait_idle();
            write_reg(REG_BODY_MODE, 32'd0);
            write_reg(REG_BODY_LENGTH, dec_body_count + 3);
            repeat (5) send_byte(8'($urandom_range(0, 255)));
         end
         CLOSE_LONG: begin
            repeat (LINE_LEN + 3) send_byte(byte_except(CH_CR, CH_LF));
            repeat (4) send_byte(8'($urandom_range(0, 255)));
            wait_idle();
            write_reg(REG_BODY_MODE, 32'd0);
            repeat (3) send_byte(8'($urandom_range(0, 255)));
         end
         default: begin
            // Nine digits overflow the size, which then sticks at all ones.
            send_byte(8'h31);
            repeat (8) send_byte($urandom_range(0, 1) ? 8'h46 : 8'h66);
            send_byte(CH_LF);
            repeat (24) send_byte(8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   always @(posedge clock) begin : result_check
      body_beat_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: result beat with no expectation waiting", $time);
               errors++;
            end else begin
               want = expected_beats.pop_front();
               check_field("payload_valid", 8'(want.payload_valid), 8'(rsp_ch.payload_valid));
               check_field("payload_byte", want.payload_byte, rsp_ch.payload_byte);
               check_field("chunk_last", 8'(want.chunk_last), 8'(rsp_ch.chunk_last));
               check_field("body_done", 8'(want.body_done), 8'(rsp_ch.body_done));
               check_field("header_error", 8'(want.header_error), 8'(rsp_ch.header_error));
            end
            if (rsp_ch.payload_valid === 1'b1) payload_seen++;
            if (rsp_ch.chunk_last === 1'b1) chunk_ends++;
         end
         if (req_ch.valid && req_ch.ready && sent_beats.size() != 0) begin
            expected_beats.push_back(sent_beats.pop_front());
         end
      end
   end

   initial begin : result_sink
      int stall;
      bit took;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 3) : 0;
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do begin
            @(posedge clock);
            took = rsp_ch.valid;
            @(negedge clock);
         end while (!took);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
             || (csr_psel && csr_penable)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      req_ch.valid   = 1'b0;
      req_ch.in_byte = 8'h00;
      steps = '{
         '{DO_BYTE, REG_BODY_MODE, 32'h00, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0}},
         '{DO_WRITE, REG_BODY_LENGTH, 32'd2, 1'b0, '0},
         '{DO_BYTE, REG_BODY_MODE, 32'hFF, 1'b1, '{1'b1, 8'hFF, 1'b0, 1'b0, 1'b0}},
         '{DO_BYTE, REG_BODY_MODE, 32'h00, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b1, 1'b0}},
         '{DO_BYTE, REG_BODY_MODE, 32'h55, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b1, 1'b0}},
         '{DO_WRITE, REG_BODY_LENGTH, 32'hFFFF_FFFF, 1'b0, '0},
         '{DO_BYTE, REG_BODY_MODE, 32'hAA, 1'b1, '{1'b1, 8'hAA, 1'b0, 1'b0, 1'b0}},
         '{DO_WRITE, REG_BODY_MODE, 32'd1, 1'b0, '0},
         '{DO_BYTE, REG_BODY_MODE, 32'h32, 1'b0, '0},
         '{DO_BYTE, REG_BODY_MODE, 32'h67, 1'b0, '0},
         '{DO_BYTE, REG_BODY_MODE, 32'h35, 1'b0, '0},
         '{DO_BYTE, REG_BODY_MODE, 32'(CH_CR), 1'b0, '0},
         '{DO_BYTE, REG_BODY_MODE, 32'(CH_CR), 1'b0, '0},
         '{DO_BYTE, REG_BODY_MODE, 32'(CH_LF), 1'b0, '0},
         '{DO_BYTE, REG_BODY_MODE, 32'(CH_CR), 1'b0, '0},
         '{DO_BYTE, REG_BODY_MODE, 32'(CH_LF), 1'b0, '0},
         '{DO_BYTE, REG_BODY_MODE, 32'h78, 1'b0, '0},
         '{DO_BYTE, REG_BODY_MODE, 32'(CH_CR), 1'b0, '0},
         '{DO_BYTE, REG_BODY_MODE, 32'(CH_LF), 1'b0, '0},
         '{DO_BYTE, REG_BODY_MODE, 32'h31, 1'b0, '0},
         '{DO_BYTE, REG_BODY_MODE, 32'(CH_LF), 1'b0, '0},
         '{DO_BYTE, REG_BODY_MODE, 32'hFF, 1'b0, '0},
         '{DO_BYTE, REG_BODY_MODE, 32'(CH_LF), 1'b0, '0}
      };
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (steps[i]) begin
         if (steps[i].kind == DO_WRITE) begin
            wait_idle();
            write_reg(steps[i].sel, steps[i].value);
         end else begin
            send_byte(steps[i].value[7:0], steps[i].typed, steps[i].beat);
         end
      end

      while (bytes_sent < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         send_chunk();
      end
      idle_on = 1'($urandom_range(0, 1));
      close_body();

      wait_idle();
      repeat (4) @(negedge clock);
      if (expected_beats.size() != 0 || sent_beats.size() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time,
                  expected_beats.size() + sent_beats.size());
         errors++;
      end
      $display("Sent %0d bytes: %0d payload beats, %0d chunk ends, %0d register writes.",
               bytes_sent, payload_seen, chunk_ends, reg_writes);
      $display("Chunked stream closed by %s; %0d mismatches.", closing.name(), errors);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[http_body_dechunker.f]
rtl/core/hbd_pkg.sv
rtl/core/hbd_req_if.sv
rtl/core/hbd_rsp_if.sv
rtl/core/hbd_chunk_parser.sv
rtl/core/http_body_dechunker.sv
dv/testbench.sv
